/* design/ptw_pkg.sv */
// Shared types, codes and helper functions for the page-table walk translate core.
package ptw_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ARCH_MODE = 2'd0;
    localparam logic [1:0] CFG_ROOT_BASE = 2'd1;
    localparam logic [1:0] CFG_MEM_SIZE  = 2'd2;

    // Input word function
    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_RESPONSE  = 1'b1;

    // Result word kind
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Table format
    localparam logic ARCH_X86 = 1'b0;
    localparam logic ARCH_ARM = 1'b1;

    // Top levels of the two formats, the directory level and the no-level code
    localparam logic [2:0] TOP_LEVEL_X86 = 3'd4;
    localparam logic [2:0] TOP_LEVEL_ARM = 3'd3;
    localparam logic [2:0] LEVEL_DIR     = 3'd2;
    localparam logic [2:0] LEVEL_NONE    = 3'd0;

    // Attribute masks: cleared bits around the frame number
    localparam logic [63:0] MASK_X86 = (64'hFF << 56) | 64'hFFF;
    localparam logic [63:0] MASK_ARM = (64'hFFFF << 48) | 64'hFFF;

    // Descriptor bits
    localparam int BIT_PRESENT = 0;
    localparam int BIT_TABLE   = 1;
    localparam int BIT_PS      = 7;

    // Size of one table entry in bytes; the walk limit is mem_size minus this
    localparam logic [63:0] ENTRY_BYTES = 64'd8;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_OUTSIDE     = 2'd2,
        ST_UNEXPECTED  = 2'd3
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [63:0] read_addr;
        logic [2:0]  level;
        logic [63:0] last_entry;
        logic [63:0] frame_base;
        logic        large_page;
        t_status     status;
    } t_result;

    // Clear attribute bits of an entry or root register
    function automatic logic [63:0] frame_of(input logic [63:0] e, input logic arm);
        frame_of = e & ~(arm ? MASK_ARM : MASK_X86);
    endfunction

    // Byte offset of the entry for a level: 9-bit index times 8
    function automatic logic [63:0] entry_offset(input logic [63:0] va,
                                                 input logic [2:0] lvl);
        logic [2:0] sel;
        logic [8:0] idx;
        sel = lvl - 3'd1;
        case (sel[1:0])
            2'd0:    idx = va[20:12];
            2'd1:    idx = va[29:21];
            2'd2:    idx = va[38:30];
            default: idx = va[47:39];
        endcase
        entry_offset = {52'd0, idx, 3'd0};
    endfunction

endpackage

/* design/page_table_walk_translate_core.sv */
// Top level of the page-table walk translate core: walk control and result buffering.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per item: a
//   translate request (i_func = 0, i_virt_addr) or a table entry read back
//   from memory (i_func = 1, i_table_entry). Every input word produces
//   exactly one result word on the output channel (o_out_valid /
//   i_out_ready): either a read request for the next table entry
//   (o_kind = 0, o_read_addr, o_level) or a finished walk (o_kind = 1)
//   with frame base, level, large-page flag and status.
//   Each result is registered in the result register, or in the skid
//   register while the receiver stalls. Throughput is one word per cycle
//   while the receiver takes words, set by the single result register; a
//   skid register holds one more result so the input stays ready for one
//   more word while the receiver stalls. With both output and skid
//   registers full, o_in_ready drops until the receiver takes a word.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_wdata) writes arch_mode,
//   root_base or mem_size, one per write; write only while idle.
//   Synchronous reset clears the walk state, the config registers and both
//   result valid flags; no clearing pass is needed.
module page_table_walk_translate_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [63:0]             i_cfg_wdata,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_func,
    input  logic [63:0]             i_virt_addr,
    input  logic [63:0]             i_table_entry,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_kind,
    output logic [63:0]             o_read_addr,
    output logic [2:0]              o_level,
    output logic [63:0]             o_last_entry,
    output logic [63:0]             o_frame_base,
    output logic                    o_large_page,
    output ptw_pkg::t_status        o_status
);
    import ptw_pkg::*;

    // configuration
    logic        r_arch_mode;
    logic [63:0] r_root_base;
    logic [63:0] r_limit;      // mem_size - 8, or 0 for tiny memories

    // walk state
    logic        r_walking, n_walking;
    logic [2:0]  r_cur_level, n_cur_level;
    logic [63:0] r_held_vaddr, n_held_vaddr;

    // result buffering
    logic        r_out_valid, r_skid_valid;
    t_result     r_out, r_skid;
    t_result     n_res;

    logic        in_acc;
    logic        out_take;

    // descend operands
    logic [63:0] d_table;
    logic [63:0] d_vaddr;
    logic [2:0]  d_level;
    logic [63:0] d_addr;
    logic        d_outside;
    logic        root_outside;
    logic [2:0]  top_level;
    logic        is_block;

    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch_mode <= ARCH_X86;
            r_root_base <= '0;
            r_limit     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ARCH_MODE: r_arch_mode <= i_cfg_wdata[0];
                CFG_ROOT_BASE: r_root_base <= i_cfg_wdata[63:0];
                CFG_MEM_SIZE:  r_limit     <= (i_cfg_wdata[63:0] >= ENTRY_BYTES)
                                              ? i_cfg_wdata[63:0] - ENTRY_BYTES : '0;
                default:       ;
            endcase
        end
    end

    // operands of the next table read
    assign top_level = (r_arch_mode == ARCH_ARM) ? TOP_LEVEL_ARM : TOP_LEVEL_X86;

    always_comb begin
        if (i_func == FUNC_TRANSLATE) begin
            d_table = r_root_base;
            d_vaddr = i_virt_addr[63:0];
            d_level = top_level;
        end else begin
            d_table = i_table_entry[63:0];
            d_vaddr = r_held_vaddr;
            d_level = r_cur_level - 3'd1;
        end
    end

    assign d_addr       = frame_of(d_table, r_arch_mode) | entry_offset(d_vaddr, d_level);
    assign d_outside    = d_addr >= r_limit;
    assign root_outside = r_root_base >= r_limit;
    assign is_block     = (r_arch_mode == ARCH_ARM)
                          ? !i_table_entry[BIT_TABLE] : i_table_entry[BIT_PS];

    // decision for one word
    always_comb begin
        n_res        = '0;
        n_walking    = r_walking;
        n_cur_level  = r_cur_level;
        n_held_vaddr = r_held_vaddr;
        if (i_func == FUNC_TRANSLATE) begin
            n_held_vaddr = i_virt_addr[63:0];
            if (root_outside || d_outside) begin
                n_walking    = 1'b0;
                n_res.kind   = KIND_FINISH;
                n_res.level  = top_level;
                n_res.status = ST_OUTSIDE;
            end else begin
                n_walking       = 1'b1;
                n_cur_level     = top_level;
                n_res.kind      = KIND_READ;
                n_res.read_addr = d_addr;
                n_res.level     = top_level;
            end
        end else if (!r_walking) begin
            n_res.kind       = KIND_FINISH;
            n_res.level      = LEVEL_NONE;
            n_res.last_entry = i_table_entry[63:0];
            n_res.status     = ST_UNEXPECTED;
        end else begin
            n_res.last_entry = i_table_entry[63:0];
            if (!i_table_entry[BIT_PRESENT]) begin
                n_walking    = 1'b0;
                n_res.kind   = KIND_FINISH;
                n_res.level  = r_cur_level;
                n_res.status = ST_NOT_PRESENT;
            end else if (r_cur_level <= 3'd1) begin
                n_walking        = 1'b0;
                n_res.kind       = KIND_FINISH;
                n_res.level      = r_cur_level;
                n_res.frame_base = frame_of(i_table_entry[63:0], r_arch_mode);
                n_res.status     = ST_OK;
            end else if (r_cur_level == LEVEL_DIR && is_block) begin
                n_walking        = 1'b0;
                n_res.kind       = KIND_FINISH;
                n_res.level      = r_cur_level;
                n_res.frame_base = frame_of(i_table_entry[63:0], r_arch_mode);
                n_res.large_page = 1'b1;
                n_res.status     = ST_OK;
            end else if (d_outside) begin
                n_walking    = 1'b0;
                n_res.kind   = KIND_FINISH;
                n_res.level  = d_level;
                n_res.status = ST_OUTSIDE;
            end else begin
                n_walking       = 1'b1;
                n_cur_level     = d_level;
                n_res.kind      = KIND_READ;
                n_res.read_addr = d_addr;
                n_res.level     = d_level;
            end
        end
    end

    // walk state update on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking    <= 1'b0;
            r_cur_level  <= LEVEL_NONE;
            r_held_vaddr <= '0;
        end else if (in_acc) begin
            r_walking    <= n_walking;
            r_cur_level  <= n_cur_level;
            r_held_vaddr <= n_held_vaddr;
        end
    end

    // output and skid valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_res;
            end
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_read_addr  = r_out.read_addr;
    assign o_level      = r_out.level;
    assign o_last_entry = r_out.last_entry;
    assign o_frame_base = r_out.frame_base;
    assign o_large_page = r_out.large_page;
    assign o_status     = r_out.status;

    // skid stage only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // an active walk always points at a real level
    a_walk_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walking |-> (r_cur_level != LEVEL_NONE))
        else $error("walking with level zero");

    // read requests carry ok status and no frame
    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_READ)
            |-> (r_out.status == ST_OK && r_out.frame_base == '0 && !r_out.large_page))
        else $error("read request with finish fields set");

    // every accepted word leaves a result buffered
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted word produced no result");

    // a read request leaves the walker active
    a_read_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_res.kind == KIND_READ) |=> r_walking)
        else $error("read issued without active walk");

endmodule
